// ===== src/ipra_pkg.sv =====
// shared widths, codes and types for the io port range allocator
// no dependencies
package ipra_pkg;

  localparam int IPRA_DEPTH = 32;
  localparam int PORT_W     = 18;
  localparam int SIZE_W     = 17;
  localparam int END_W      = 19;

  localparam logic [PORT_W-1:0] SENTINEL_START = 18'h20000;
  localparam logic [PORT_W-1:0] SENTINEL_STOP  = 18'h20001;
  localparam logic [PORT_W-1:0] BASE_RESET     = 18'h00400;
  localparam logic [PORT_W-1:0] PORT_MAX       = 18'h3ffff;
  localparam logic [PORT_W-1:0] VGA_A_LO       = 18'h002b0;
  localparam logic [END_W-1:0]  VGA_A_END      = 19'h002e0;
  localparam logic [PORT_W-1:0] VGA_B_LO       = 18'h003c0;
  localparam logic [END_W-1:0]  VGA_B_END      = 19'h003db;

  typedef enum logic [1:0] {
    CMD_FIXED = 2'd0,
    CMD_ANY   = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic stop_gt_port;
    logic start_lt_stopq;
    logic start_ge_port;
    logic start_eq_port;
    logic access_hit;
  } cell_flags_t;

endpackage

// ===== src/io_port_range_allocator.sv =====
// io port range allocator: fixed and first-fit allocation, free, access check.
// fixed, free and check items are decided in the exec state and their result is
// registered through the result state; first-fit walks the table one entry at a
// time from the base, each entry with a nonzero alignment waiting on the divider.
// one item in flight; a stalled result holds the next. synchronous reset leaves
// only the sentinel range.
module io_port_range_allocator import ipra_pkg::*; #(
  parameter int TABLE_DEPTH = IPRA_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [PORT_W-1:0] in_port,
  input  logic [SIZE_W-1:0] in_size,
  input  logic [SIZE_W-1:0] in_align,
  input  logic [END_W-1:0]  in_range_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [PORT_W-1:0] out_granted_port,
  input  logic              cfg_we,
  input  logic [PORT_W-1:0] cfg_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_WALK = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RES  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    TBL_NONE = 2'd0,
    TBL_INS  = 2'd1,
    TBL_DEL  = 2'd2
  } tbl_op_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [PORT_W-1:0] port_r;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] align_r;
  logic [END_W-1:0]  rend_r;
  logic [PORT_W-1:0] base_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [END_W-1:0]  cur_r, cur_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [PORT_W-1:0] res_port_r, res_port_nxt;
  tbl_op_t           tbl_op_r, tbl_op_nxt;
  logic [CW-1:0]     tbl_pos_r, tbl_pos_nxt;
  logic [PORT_W-1:0] new_start_r, new_start_nxt;
  logic [PORT_W-1:0] new_stop_r, new_stop_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [PORT_W-1:0] out_port_r;

  logic [PORT_W-1:0] cell_start [TABLE_DEPTH];
  logic [PORT_W-1:0] cell_stop  [TABLE_DEPTH];
  cell_flags_t       cell_flags [TABLE_DEPTH];
  cell_op_t          cell_op    [TABLE_DEPTH];

  logic              out_free;
  logic              commit;
  logic [END_W-1:0]  stopq;
  logic              fx_hit, fx_clash, fr_hit, fr_eq, acc_hit, vga_ok;
  logic [CW-1:0]     fx_idx, fr_idx;
  logic [PORT_W-1:0] rd_start, rd_stop;
  logic [END_W-1:0]  gap;
  logic [END_W:0]    end_sum;
  logic              walk_found;
  logic              div_go, div_done;
  logic [END_W-1:0]  div_rounded;
  logic              table_full;

  assign out_free   = !out_valid_r || !out_stall;
  assign commit     = (state_r == ST_RES) && out_free;
  assign in_stall   = state_r != ST_IDLE;
  assign stopq      = {1'b0, port_r} + END_W'(size_r);
  assign table_full = count_r >= CW'(TABLE_DEPTH);

  // the chain of entries
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    always_comb begin
      cell_op[k] = CELL_HOLD;
      if (commit && tbl_op_r == TBL_INS) begin
        if (CW'(k) == tbl_pos_r) cell_op[k] = CELL_LOAD;
        else if (CW'(k) > tbl_pos_r) cell_op[k] = CELL_LEFT;
      end else if (commit && tbl_op_r == TBL_DEL) begin
        if (CW'(k) >= tbl_pos_r) cell_op[k] = CELL_RIGHT;
      end
    end

    ipra_cell #(.IS_HEAD(k == 0)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (cell_op[k]),
      .load_start (new_start_r),
      .load_stop  (new_stop_r),
      .left_start (cell_start[(k == 0) ? 0 : k - 1]),
      .left_stop  (cell_stop[(k == 0) ? 0 : k - 1]),
      .right_start(cell_start[(k == TABLE_DEPTH - 1) ? k : k + 1]),
      .right_stop (cell_stop[(k == TABLE_DEPTH - 1) ? k : k + 1]),
      .port       (port_r),
      .stopq      (stopq),
      .rend       (rend_r),
      .start      (cell_start[k]),
      .stop       (cell_stop[k]),
      .flags      (cell_flags[k])
    );
  end

  // first matching entry: scan from the top so the lowest index wins
  always_comb begin
    fx_hit   = 1'b0;
    fx_clash = 1'b0;
    fx_idx   = count_r;
    fr_hit   = 1'b0;
    fr_eq    = 1'b0;
    fr_idx   = '0;
    acc_hit  = 1'b0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (CW'(k) < count_r) begin
        if (cell_flags[k].stop_gt_port) begin
          fx_hit   = 1'b1;
          fx_clash = cell_flags[k].start_lt_stopq;
          fx_idx   = CW'(k);
        end
        if (cell_flags[k].start_ge_port) begin
          fr_hit = 1'b1;
          fr_eq  = cell_flags[k].start_eq_port;
          fr_idx = CW'(k);
        end
        if (cell_flags[k].access_hit) acc_hit = 1'b1;
      end
    end
  end

  assign vga_ok = (port_r >= VGA_A_LO && rend_r <= VGA_A_END) ||
                  (port_r >= VGA_B_LO && rend_r <= VGA_B_END);

  assign rd_start   = cell_start[idx_r[IW-1:0]];
  assign rd_stop    = cell_stop[idx_r[IW-1:0]];
  assign gap        = {1'b0, rd_start} - cur_r;
  assign walk_found = ({1'b0, rd_start} > cur_r) && (gap > END_W'(size_r));
  assign end_sum    = {1'b0, cur_r} + (END_W + 1)'(size_r);
  assign div_go     = (state_r == ST_WALK) && (idx_r < count_r) && !walk_found &&
                      (align_r != '0);

  ipra_align u_align (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go),
    .dividend(rd_stop),
    .divisor (align_r),
    .done    (div_done),
    .rounded (div_rounded)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cur_nxt        = cur_r;
    res_status_nxt = res_status_r;
    res_port_nxt   = res_port_r;
    tbl_op_nxt     = tbl_op_r;
    tbl_pos_nxt    = tbl_pos_r;
    new_start_nxt  = new_start_r;
    new_stop_nxt   = new_stop_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        res_status_nxt = STAT_OK;
        res_port_nxt   = '0;
        tbl_op_nxt     = TBL_NONE;
        state_nxt      = ST_RES;
        case (cmd_r)
          CMD_FIXED: begin
            if (stopq > {1'b0, PORT_MAX} || (fx_hit && fx_clash)) begin
              res_status_nxt = STAT_REFUSED;
            end else begin
              res_port_nxt  = port_r;
              tbl_pos_nxt   = fx_idx;
              new_start_nxt = port_r;
              new_stop_nxt  = stopq[PORT_W-1:0];
              if (table_full) res_status_nxt = STAT_FULL;
              else tbl_op_nxt = TBL_INS;
            end
          end
          CMD_ANY: begin
            idx_nxt   = '0;
            cur_nxt   = {1'b0, base_r};
            state_nxt = ST_WALK;
          end
          CMD_FREE: begin
            if (fr_hit && fr_eq) begin
              tbl_op_nxt  = TBL_DEL;
              tbl_pos_nxt = fr_idx;
            end
          end
          default: begin
            if (!vga_ok && acc_hit) res_status_nxt = STAT_REFUSED;
          end
        endcase
      end
      ST_WALK: begin
        if (idx_r >= count_r) begin
          res_status_nxt = STAT_REFUSED;
          state_nxt      = ST_RES;
        end else if (walk_found) begin
          state_nxt = ST_RES;
          if (end_sum > (END_W + 1)'(PORT_MAX)) begin
            res_status_nxt = STAT_REFUSED;
          end else begin
            res_port_nxt  = cur_r[PORT_W-1:0];
            tbl_pos_nxt   = idx_r;
            new_start_nxt = cur_r[PORT_W-1:0];
            new_stop_nxt  = end_sum[PORT_W-1:0];
            if (table_full) res_status_nxt = STAT_FULL;
            else tbl_op_nxt = TBL_INS;
          end
        end else if (align_r == '0) begin
          cur_nxt = (rd_stop < base_r) ? {1'b0, base_r} : {1'b0, rd_stop};
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cur_nxt   = (div_rounded < {1'b0, base_r}) ? {1'b0, base_r} : div_rounded;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_RES: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CW'(1);
      base_r      <= BASE_RESET;
      out_valid_r <= 1'b0;
      tbl_op_r    <= TBL_NONE;
    end else begin
      state_r  <= state_nxt;
      tbl_op_r <= tbl_op_nxt;
      if (cfg_we) base_r <= cfg_data;
      if (commit) begin
        out_valid_r <= 1'b1;
        if (tbl_op_r == TBL_INS) count_r <= count_r + 1'b1;
        else if (tbl_op_r == TBL_DEL) count_r <= count_r - 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r   <= cmd_t'(in_command);
      port_r  <= in_port;
      size_r  <= in_size;
      align_r <= in_align;
      rend_r  <= in_range_end;
    end
    idx_r        <= idx_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_port_r   <= res_port_nxt;
    tbl_pos_r    <= tbl_pos_nxt;
    new_start_r  <= new_start_nxt;
    new_stop_r   <= new_stop_nxt;
    if (commit) begin
      out_status_r <= res_status_r;
      out_port_r   <= res_port_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_port = out_port_r;

endmodule

// ===== src/ipra_cell.sv =====
// one table entry of the range chain: holds a range, shifts to/from neighbours
// and compares it against the current item; uses ipra_pkg
module ipra_cell import ipra_pkg::*; #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_op_t          op,
  input  logic [PORT_W-1:0] load_start,
  input  logic [PORT_W-1:0] load_stop,
  input  logic [PORT_W-1:0] left_start,
  input  logic [PORT_W-1:0] left_stop,
  input  logic [PORT_W-1:0] right_start,
  input  logic [PORT_W-1:0] right_stop,
  input  logic [PORT_W-1:0] port,
  input  logic [END_W-1:0]  stopq,
  input  logic [END_W-1:0]  rend,
  output logic [PORT_W-1:0] start,
  output logic [PORT_W-1:0] stop,
  output cell_flags_t       flags
);

  logic [PORT_W-1:0] start_r;
  logic [PORT_W-1:0] stop_r;

  always_ff @(posedge clk) begin
    if (IS_HEAD && !rst_n) begin
      start_r <= SENTINEL_START;
      stop_r  <= SENTINEL_STOP;
    end else begin
      case (op)
        CELL_LOAD: begin
          start_r <= load_start;
          stop_r  <= load_stop;
        end
        CELL_LEFT: begin
          start_r <= left_start;
          stop_r  <= left_stop;
        end
        CELL_RIGHT: begin
          start_r <= right_start;
          stop_r  <= right_stop;
        end
        default: begin
          start_r <= start_r;
          stop_r  <= stop_r;
        end
      endcase
    end
  end

  assign start = start_r;
  assign stop  = stop_r;

  always_comb begin
    flags.stop_gt_port   = stop_r > port;
    flags.start_lt_stopq = {1'b0, start_r} < stopq;
    flags.start_ge_port  = start_r >= port;
    flags.start_eq_port  = start_r == port;
    flags.access_hit     = (port >= start_r && port < stop_r) ||
                           (port <= start_r && rend > {1'b0, start_r});
  end

endmodule

// ===== src/ipra_align.sv =====
// rounds a range stop up to a multiple of the alignment, one remainder bit
// per cycle; uses ipra_pkg
module ipra_align import ipra_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [PORT_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [END_W-1:0]  rounded
);

  localparam int CNT_W = $clog2(PORT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PORT_W-1:0] dq_r;
  logic [PORT_W-1:0] hold_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;

  assign trial = {rem_r, dq_r[PORT_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PORT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dq_r   <= dividend;
      hold_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[PORT_W-2:0], 1'b0};
      rem_r <= (trial >= {1'b0, divisor}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end
  end

  assign done    = done_r;
  // stop plus the distance to the next multiple
  assign rounded = (rem_r == '0) ? {1'b0, hold_r}
                 : {1'b0, hold_r} + END_W'(divisor) - END_W'(rem_r);

endmodule

// ===== src/ipra_checker.sv =====
// port-level checks for the io port range allocator, bound to the top level
// uses ipra_pkg codes
module ipra_checker import ipra_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic [PORT_W-1:0] out_granted_port
);

  // a result only ever carries a defined status
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_REFUSED ||
                   out_status == STAT_FULL))
    else $error("undefined status code");

  // refusals carry no port
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_REFUSED) |-> out_granted_port == '0)
    else $error("refused item carries a port");

  // an accepted item is never followed by a taken input in the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_granted_port)))
    else $error("stalled result changed");

endmodule

bind io_port_range_allocator ipra_checker u_ipra_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_granted_port(out_granted_port)
);
